// File: rtl/mssc_pkg.sv
package mssc_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned FramesW  = 7;
  localparam int unsigned SegW     = 7;

  localparam logic [FramesW-1:0] FramesPerCountRst   = 7'd100;
  localparam logic [FramesW-1:0] FramesPerSetStepRst = 7'd10;

  localparam logic [3:0] DecLimit     = 4'd10;
  localparam logic [3:0] SecTensLimit = 4'd6;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAMES_PER_COUNT    = 2'd0,
    CFG_FRAMES_PER_SET_STEP = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_COUNT   = 2'd0,
    KIND_MIN_SET = 2'd1,
    KIND_SEC_SET = 2'd2
  } period_kind_e;

  typedef enum logic [1:0] {
    SLOT_SEC_ONES = 2'd0,
    SLOT_SEC_TENS = 2'd1,
    SLOT_MIN_ONES = 2'd2,
    SLOT_MIN_TENS = 2'd3
  } slot_e;

  typedef struct packed {
    logic       wrap;
    logic [3:0] digit;
  } bump_t;

  // Steps one decimal digit; wraps to zero once the limit is reached.
  function automatic bump_t bump_digit(logic [3:0] d, logic [3:0] limit);
    bump_t r;
    logic [4:0] nxt;
    nxt = {1'b0, d} + 5'd1;
    if (nxt >= {1'b0, limit}) begin
      r.wrap  = 1'b1;
      r.digit = 4'd0;
    end else begin
      r.wrap  = 1'b0;
      r.digit = nxt[3:0];
    end
    return r;
  endfunction

  // Segment pattern, bit 0 is segment a. Codes above nine are blank.
  function automatic logic [SegW-1:0] seg_decode(logic [3:0] d);
    logic [SegW-1:0] s;
    case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

// File: rtl/multiplexed_seven_segment_clock.sv
// Latency: a result is valid in the cycle after its item is accepted.
// Throughput: one item per cycle; the single output register is refilled in the
// same cycle its result is taken, so only a stalled, full output holds off input.
// Reset (asynchronous, active low) clears the time to 00:00, starts a counting
// period of 100 frames at the seconds-ones slot and restores the register
// defaults of 100 and 10 frames.
module multiplexed_seven_segment_clock (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                minute_button_i,
  input  logic                                second_button_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          digit_select_o,
  output logic [mssc_pkg::SegW-1:0]           segments_o,
  output logic [1:0]                          setting_mode_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mssc_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [mssc_pkg::FramesW-1:0]        cfg_data_i
);
  import mssc_pkg::*;

  logic [FramesW-1:0] frames_per_count_q, frames_per_set_step_q;
  logic [3:0]         min_tens_q, min_tens_d;
  logic [3:0]         min_ones_q, min_ones_d;
  logic [2:0]         sec_tens_q, sec_tens_d;
  logic [3:0]         sec_ones_q, sec_ones_d;
  logic [1:0]         slot_q, slot_d;
  logic [FramesW-1:0] frames_left_q, frames_left_d;
  period_kind_e       kind_q, kind_d;

  logic               out_valid_q;
  logic [1:0]         digit_sel_q;
  logic [SegW-1:0]    segments_q;
  logic [1:0]         mode_q;

  logic               in_accept;
  logic [3:0]         cur_digit;
  bump_t              min_ones_b, min_tens_b, sec_ones_b, sec_tens_b;
  logic [3:0]         min_tens_inc, min_ones_inc;
  logic [2:0]         sec_tens_inc;
  logic [3:0]         sec_ones_inc;
  logic               sec_wrap;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_accept   = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_per_count_q    <= FramesPerCountRst;
      frames_per_set_step_q <= FramesPerSetStepRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_FRAMES_PER_COUNT:    frames_per_count_q    <= cfg_data_i;
        CFG_FRAMES_PER_SET_STEP: frames_per_set_step_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (slot_q)
      SLOT_SEC_ONES: cur_digit = sec_ones_q;
      SLOT_SEC_TENS: cur_digit = {1'b0, sec_tens_q};
      SLOT_MIN_ONES: cur_digit = min_ones_q;
      default:       cur_digit = min_tens_q;
    endcase
  end

  // Increment candidates for the minutes and the seconds.
  assign min_ones_b = bump_digit(min_ones_q, DecLimit);
  assign min_tens_b = bump_digit(min_tens_q, DecLimit);
  assign sec_ones_b = bump_digit(sec_ones_q, DecLimit);
  assign sec_tens_b = bump_digit({1'b0, sec_tens_q}, SecTensLimit);

  assign min_ones_inc = min_ones_b.digit;
  assign min_tens_inc = min_ones_b.wrap ? min_tens_b.digit : min_tens_q;
  assign sec_ones_inc = sec_ones_b.digit;
  assign sec_tens_inc = sec_ones_b.wrap ? sec_tens_b.digit[2:0] : sec_tens_q;
  assign sec_wrap     = sec_ones_b.wrap & sec_tens_b.wrap;

  always_comb begin
    min_tens_d    = min_tens_q;
    min_ones_d    = min_ones_q;
    sec_tens_d    = sec_tens_q;
    sec_ones_d    = sec_ones_q;
    slot_d        = slot_q;
    frames_left_d = frames_left_q;
    kind_d        = kind_q;
    if (in_accept) begin
      slot_d = slot_q + 2'd1;
      if (slot_q == SLOT_MIN_TENS) begin
        if (frames_left_q <= FramesW'(1)) begin
          // Period ends: buttons are active low, minute button wins.
          if (!minute_button_i) begin
            min_tens_d    = min_tens_inc;
            min_ones_d    = min_ones_inc;
            kind_d        = KIND_MIN_SET;
            frames_left_d = frames_per_set_step_q;
          end else if (!second_button_i) begin
            sec_tens_d    = sec_tens_inc;
            sec_ones_d    = sec_ones_inc;
            kind_d        = KIND_SEC_SET;
            frames_left_d = frames_per_set_step_q;
          end else begin
            sec_tens_d    = sec_tens_inc;
            sec_ones_d    = sec_ones_inc;
            if (sec_wrap) begin
              min_tens_d = min_tens_inc;
              min_ones_d = min_ones_inc;
            end
            kind_d        = KIND_COUNT;
            frames_left_d = frames_per_count_q;
          end
        end else begin
          frames_left_d = frames_left_q - FramesW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_tens_q    <= '0;
      min_ones_q    <= '0;
      sec_tens_q    <= '0;
      sec_ones_q    <= '0;
      slot_q        <= SLOT_SEC_ONES;
      frames_left_q <= FramesPerCountRst;
      kind_q        <= KIND_COUNT;
      out_valid_q   <= 1'b0;
    end else begin
      min_tens_q    <= min_tens_d;
      min_ones_q    <= min_ones_d;
      sec_tens_q    <= sec_tens_d;
      sec_ones_q    <= sec_ones_d;
      slot_q        <= slot_d;
      frames_left_q <= frames_left_d;
      kind_q        <= kind_d;
      if (in_accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload, loaded with the item it belongs to.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      digit_sel_q <= slot_q;
      segments_q  <= seg_decode(cur_digit);
      mode_q      <= kind_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign digit_select_o = digit_sel_q;
  assign segments_o     = segments_q;
  assign setting_mode_o = mode_q;

  a_slot_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> slot_q == $past(slot_q) + 2'd1)
    else $error("slot index did not advance on an accepted item");

  a_slot_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_accept |=> $stable(slot_q))
    else $error("slot index moved without an item");

  a_frames_only_at_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_accept && slot_q == SLOT_MIN_TENS) |=> $stable(frames_left_q))
    else $error("frame count changed outside a frame end");

  a_sec_tens_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_tens_q <= 3'd5)
    else $error("seconds tens digit out of range");

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q)
    else $error("input stalled with an empty result register");

endmodule

// File: test/multiplexed_seven_segment_clock_test.sv
`timescale 1ns / 1ps

module multiplexed_seven_segment_clock_test;
  import mssc_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned IDLE_PCT    = 38;
  localparam int unsigned MAX_REPORTS = 10;

  localparam logic [SegW-1:0] GLYPH [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };

  typedef struct {
    slot_e           digit;
    logic [SegW-1:0] segments;
    period_kind_e    kind;
  } slot_view_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 minute_button_i = 1'b1;
  logic                 second_button_i = 1'b1;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [1:0]           digit_select_o;
  logic [SegW-1:0]      segments_o;
  logic [1:0]           setting_mode_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [FramesW-1:0]   cfg_data_i = '0;

  multiplexed_seven_segment_clock DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .minute_button_i (minute_button_i),
    .second_button_i (second_button_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .digit_select_o  (digit_select_o),
    .segments_o      (segments_o),
    .setting_mode_o  (setting_mode_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Clock state as the display should show it.
  logic [3:0]         min_tens_q;
  logic [3:0]         min_ones_q;
  logic [2:0]         sec_tens_q;
  logic [3:0]         sec_ones_q;
  slot_e              scan_slot;
  logic [FramesW-1:0] frames_remaining;
  period_kind_e       shown_kind;
  logic [FramesW-1:0] count_frames;
  logic [FramesW-1:0] step_frames;

  slot_view_t pending_slots[$];
  int unsigned mismatch_count = 0;
  int unsigned slots_sent = 0;
  int unsigned writes_done = 0;
  int unsigned quiet_cycles = 0;
  bit calm = 1'b0;

  function automatic logic [SegW-1:0] glyph(logic [3:0] d);
    return (d < 4'd10) ? GLYPH[d] : '0;
  endfunction

  // Returns {wrapped, next digit}.
  function automatic logic [4:0] tick_digit(logic [3:0] d, logic [3:0] lim);
    if (({1'b0, d} + 5'd1) >= {1'b0, lim}) begin
      return {1'b1, 4'd0};
    end
    return {1'b0, d + 4'd1};
  endfunction

  task automatic advance_minutes();
    logic [4:0] r;
    r = tick_digit(min_ones_q, DecLimit);
    min_ones_q = r[3:0];
    if (r[4]) begin
      r = tick_digit(min_tens_q, DecLimit);
      min_tens_q = r[3:0];
    end
  endtask

  task automatic advance_seconds(output logic carry);
    logic [4:0] r;
    r = tick_digit(sec_ones_q, DecLimit);
    sec_ones_q = r[3:0];
    carry = 1'b0;
    if (r[4]) begin
      r = tick_digit({1'b0, sec_tens_q}, SecTensLimit);
      sec_tens_q = r[2:0];
      carry = r[4];
    end
  endtask

  task automatic reset_clock_state();
    min_tens_q = '0;
    min_ones_q = '0;
    sec_tens_q = '0;
    sec_ones_q = '0;
    scan_slot = SLOT_SEC_ONES;
    frames_remaining = FramesPerCountRst;
    shown_kind = KIND_COUNT;
    count_frames = FramesPerCountRst;
    step_frames = FramesPerSetStepRst;
  endtask

  task automatic predict_slot(input logic mb, input logic sb, output slot_view_t v);
    logic [3:0] shown;
    logic carry;
    case (scan_slot)
      SLOT_SEC_ONES: shown = sec_ones_q;
      SLOT_SEC_TENS: shown = {1'b0, sec_tens_q};
      SLOT_MIN_ONES: shown = min_ones_q;
      default:       shown = min_tens_q;
    endcase
    v.digit = scan_slot;
    v.segments = glyph(shown);
    v.kind = shown_kind;
    if (scan_slot == SLOT_MIN_TENS) begin
      scan_slot = SLOT_SEC_ONES;
      // Buttons only matter on the last slot of the last frame of a period.
      if (frames_remaining <= 7'd1) begin
        if (!mb) begin
          advance_minutes();
          shown_kind = KIND_MIN_SET;
          frames_remaining = step_frames;
        end else if (!sb) begin
          advance_seconds(carry);
          shown_kind = KIND_SEC_SET;
          frames_remaining = step_frames;
        end else begin
          advance_seconds(carry);
          if (carry) begin
            advance_minutes();
          end
          shown_kind = KIND_COUNT;
          frames_remaining = count_frames;
        end
      end else begin
        frames_remaining = frames_remaining - 7'd1;
      end
    end else begin
      scan_slot = slot_e'(scan_slot + 2'd1);
    end
  endtask

  function automatic bit want_idle();
    return !calm && ($urandom_range(99) < IDLE_PCT);
  endfunction

  task automatic send_slot(input logic mb, input logic sb);
    slot_view_t v;
    while (want_idle()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    minute_button_i <= mb;
    second_button_i <= sb;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_slot(mb, sb, v);
    pending_slots.push_back(v);
    slots_sent++;
  endtask

  // Sends slots up to the end of the current frame; the given levels are
  // held on the frame's last slot, other slots carry random levels.
  task automatic run_frame(input logic mb, input logic sb);
    logic last;
    do begin
      last = (scan_slot == SLOT_MIN_TENS);
      if (last) begin
        send_slot(mb, sb);
      end else begin
        send_slot(1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end while (!last);
  endtask

  task automatic run_period(input logic mb, input logic sb);
    logic ending;
    do begin
      ending = (frames_remaining <= 7'd1);
      run_frame(mb, sb);
    end while (!ending);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_slots.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [FramesW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    if (idx == CFG_FRAMES_PER_COUNT) begin
      count_frames = val;
    end else begin
      step_frames = val;
    end
    writes_done++;
  endtask

  task automatic drive_to(input logic [3:0] mt, input logic [3:0] mo,
                          input logic [2:0] st, input logic [3:0] so);
    logic min_off;
    logic sec_off;
    min_off = {min_tens_q, min_ones_q} != {mt, mo};
    sec_off = {sec_tens_q, sec_ones_q} != {st, so};
    while (min_off || sec_off) begin
      if (min_off && (!sec_off || $urandom_range(1) == 0)) begin
        run_period(1'b0, 1'($urandom_range(1)));
      end else begin
        run_period(1'b1, 1'b0);
      end
      min_off = {min_tens_q, min_ones_q} != {mt, mo};
      sec_off = {sec_tens_q, sec_ones_q} != {st, so};
    end
  endtask

  // Zero-length registers act as one frame, but only once the long
  // period that starts at reset has run out.
  task automatic test_first_period();
    wait_idle();
    write_reg(CFG_FRAMES_PER_COUNT, 7'd0);
    write_reg(CFG_FRAMES_PER_SET_STEP, 7'd0);
    repeat (2) begin
      send_slot(1'b0, 1'b0);
      send_slot(1'b0, 1'b1);
      send_slot(1'b1, 1'b0);
      send_slot(1'b1, 1'b1);
    end
    run_period(1'b0, 1'b0);
  endtask

  task automatic test_button_levels();
    run_period(1'b1, 1'b0);
    run_period(1'b1, 1'b1);
    run_period(1'b0, 1'b1);
    run_period(1'b0, 1'b0);
    run_period(1'b1, 1'b1);
  endtask

  // The longest set period, with a register change halfway through it.
  task automatic test_register_extremes();
    wait_idle();
    write_reg(CFG_FRAMES_PER_COUNT, 7'd127);
    write_reg(CFG_FRAMES_PER_SET_STEP, 7'd127);
    run_period(1'b1, 1'b0);
    repeat (60) run_frame(1'b1, 1'b0);
    wait_idle();
    write_reg(CFG_FRAMES_PER_SET_STEP, 7'd1);
    write_reg(CFG_FRAMES_PER_COUNT, 7'd1);
    run_period(1'b1, 1'b0);
    run_period(1'b1, 1'b0);
    run_period(1'b1, 1'b1);
    run_period(1'b1, 1'b1);
  endtask

  task automatic test_time_wraps();
    wait_idle();
    write_reg(CFG_FRAMES_PER_SET_STEP, 7'd1);
    write_reg(CFG_FRAMES_PER_COUNT, 7'd2);
    calm = 1'b1;
    drive_to(4'd9, 4'd9, 3'd5, 4'd9);
    calm = 1'b0;
    run_period(1'b0, 1'($urandom_range(1)));
    drive_to(4'd9, 4'd9, 3'd5, 4'd9);
    // Setting the seconds past 59 must not touch the minutes.
    run_period(1'b1, 1'b0);
    drive_to(4'd9, 4'd9, 3'd5, 4'd9);
    run_period(1'b1, 1'b1);
  endtask

  task automatic test_random_mix();
    int unsigned start;
    logic mb;
    logic sb;
    start = slots_sent;
    while (slots_sent - start < 500) begin
      if ($urandom_range(7) == 0) begin
        wait_idle();
        write_reg(cfg_reg_e'($urandom_range(1)), 7'($urandom_range(4)));
      end
      if ($urandom_range(9) < 3) begin
        send_slot(1'($urandom_range(1)), 1'($urandom_range(1)));
      end else begin
        case ($urandom_range(2))
          0: begin
            mb = 1'b0;
            sb = 1'($urandom_range(1));
          end
          1: begin
            mb = 1'b1;
            sb = 1'b0;
          end
          default: begin
            mb = 1'b1;
            sb = 1'b1;
          end
        endcase
        run_period(mb, sb);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
        $display("%0t: %s expected %0h, got %0h", $realtime, name, want, got);
      end
    end
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= want_idle();
  end

  always @(posedge clk_i) begin
    slot_view_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_slots.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("%0t: result with no item outstanding", $realtime);
        end
      end else begin
        want = pending_slots.pop_front();
        check_field("digit_select", 8'(want.digit), 8'(digit_select_o));
        check_field("segments", 8'(want.segments), 8'(segments_o));
        check_field("setting_mode", 8'(want.kind), 8'(setting_mode_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    reset_clock_state();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_first_period();
    test_button_levels();
    test_register_extremes();
    test_time_wraps();
    test_random_mix();
    wait_idle();
    repeat (4) @(posedge clk_i);
    $display("Sent %0d slot items and %0d register writes, including set and count",
             slots_sent, writes_done);
    $display("wraps of 99:59, both-button priority and zero-length periods.");
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: multiplexed_seven_segment_clock.f
rtl/mssc_pkg.sv
rtl/multiplexed_seven_segment_clock.sv
test/multiplexed_seven_segment_clock_test.sv
